// ----- rtl/b64sd_pkg.sv -----
// ----------------------------------------------------------------------------
// b64sd_pkg
// Shared types, constants and the alphabet lookup for the Base64 stream
// decoder.
// ----------------------------------------------------------------------------
package b64sd_pkg;

  localparam int COUNT_BITS_DEF = 16;
  localparam int MAX_RESULTS    = 4;

  localparam logic [7:0] PAD_CHAR = 8'h3D;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data;
    logic [15:0] len;
  } result_t;

  // bit 6 set: not in the alphabet
  function automatic logic [6:0] sextet_of(input logic [7:0] c);
    logic [6:0] v;
    v = 7'd64;
    if (c >= 8'h41 && c <= 8'h5A) begin
      v = 7'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      v = 7'(c - 8'h61 + 8'd26);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      v = 7'(c - 8'h30 + 8'd52);
    end else if (c == 8'h2B) begin
      v = 7'd62;
    end else if (c == 8'h2F) begin
      v = 7'd63;
    end
    return v;
  endfunction

endpackage

// ----- rtl/base64_stream_decoder.sv -----
// ----------------------------------------------------------------------------
// base64_stream_decoder
// Decodes one Base64 character per transfer into data, done and error results.
// ----------------------------------------------------------------------------
// The first result of an item is registered and is on the output in the cycle after its transfer.
// Throughput: one item per cycle while out_ready is held high and each item gives at
//   most one result; an item that gives several results holds the output register
//   until each is transferred, and the input waits until the last of them is transferred.
// Reset: synchronous; clears decoding state, the limit register and the output.
module base64_stream_decoder #(
  parameter int COUNT_BITS = b64sd_pkg::COUNT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write_en,
  input  logic [15:0] cfg_write_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  symbol,
  input  logic        end_of_string,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  kind,
  output logic [7:0]  data_byte,
  output logic [15:0] total_len,
  output logic        last_of_run
);

  localparam int NR = b64sd_pkg::MAX_RESULTS;

  logic [15:0]           max_output_len;
  logic [1:0]            quad_position, quad_position_next;
  logic [17:0]           held_sextets, held_sextets_next;
  logic                  third_was_pad, third_was_pad_next;
  logic [COUNT_BITS-1:0] byte_count, byte_count_next;
  logic                  skipping_rest, skipping_rest_next;

  b64sd_pkg::result_t    res [NR];
  b64sd_pkg::result_t    res_next [NR];
  logic [2:0]            nres_next;
  logic [1:0]            last_idx;
  logic [1:0]            idx;
  logic                  pend_valid;
  logic                  out_fire, in_fire, pend_done;

  assign out_valid   = pend_valid;
  assign out_fire    = pend_valid && out_ready;
  assign pend_done   = out_fire && (idx == last_idx);
  assign in_ready    = !pend_valid || pend_done;
  assign in_fire     = in_valid && in_ready;

  assign kind        = res[idx].kind;
  assign data_byte   = res[idx].data;
  assign total_len   = res[idx].len;
  assign last_of_run = (idx == last_idx);

  always_comb begin
    logic [6:0]            v;
    logic                  pad;
    logic [COUNT_BITS-1:0] cnt;
    logic                  stop;
    logic [1:0]            nbytes;
    logic [5:0]            s1, s2, s3, s4;
    logic [7:0]            bytes [3];

    quad_position_next = quad_position;
    held_sextets_next  = held_sextets;
    third_was_pad_next = third_was_pad;
    byte_count_next    = byte_count;
    skipping_rest_next = skipping_rest;
    nres_next          = 3'd0;
    for (int k = 0; k < NR; k++) begin
      res_next[k] = '0;
    end

    v      = b64sd_pkg::sextet_of(symbol);
    pad    = (symbol == b64sd_pkg::PAD_CHAR);
    cnt    = byte_count;
    stop   = 1'b0;
    s1     = held_sextets[17:12];
    s2     = held_sextets[11:6];
    s3     = held_sextets[5:0];
    s4     = pad ? 6'd0 : v[5:0];
    nbytes = third_was_pad ? 2'd1 : (pad ? 2'd2 : 2'd3);
    bytes[0] = {s1, s2[5:4]};
    bytes[1] = {s2[3:0], s3[5:2]};
    bytes[2] = {s3[1:0], s4};

    if (skipping_rest) begin
      if (end_of_string) begin
        quad_position_next = '0;
        held_sextets_next  = '0;
        third_was_pad_next = 1'b0;
        byte_count_next    = '0;
        skipping_rest_next = 1'b0;
      end
    end else if (v[6] && (!pad || quad_position < 2'd2)) begin
      res_next[0].kind   = b64sd_pkg::KIND_ERROR;
      res_next[0].len    = 16'(byte_count);
      nres_next          = 3'd1;
      quad_position_next = '0;
      held_sextets_next  = '0;
      third_was_pad_next = 1'b0;
      skipping_rest_next = !end_of_string;
      if (end_of_string) begin
        byte_count_next = '0;
      end
    end else if (quad_position < 2'd3) begin
      held_sextets_next  = {held_sextets[11:0], (pad ? 6'd0 : v[5:0])};
      third_was_pad_next = third_was_pad || pad;
      quad_position_next = quad_position + 2'd1;
      if (end_of_string) begin
        res_next[0].kind   = b64sd_pkg::KIND_ERROR;
        res_next[0].len    = 16'(byte_count);
        nres_next          = 3'd1;
        quad_position_next = '0;
        held_sextets_next  = '0;
        third_was_pad_next = 1'b0;
        byte_count_next    = '0;
      end
    end else begin
      for (int i = 0; i < 3; i++) begin
        if (2'(i) < nbytes && !stop) begin
          if (max_output_len != 16'd0 && 32'(cnt) >= 32'(max_output_len)) begin
            res_next[nres_next[1:0]].kind = b64sd_pkg::KIND_ERROR;
            res_next[nres_next[1:0]].len  = 16'(cnt);
            nres_next = nres_next + 3'd1;
            stop      = 1'b1;
          end else begin
            if (cnt != '1) begin
              cnt = cnt + COUNT_BITS'(1);
            end
            res_next[nres_next[1:0]].kind = b64sd_pkg::KIND_DATA;
            res_next[nres_next[1:0]].data = bytes[i];
            res_next[nres_next[1:0]].len  = 16'(cnt);
            nres_next = nres_next + 3'd1;
          end
        end
      end
      quad_position_next = '0;
      held_sextets_next  = '0;
      third_was_pad_next = 1'b0;
      byte_count_next    = cnt;
      if (!stop && (pad || end_of_string)) begin
        res_next[nres_next[1:0]].kind = b64sd_pkg::KIND_DONE;
        res_next[nres_next[1:0]].len  = 16'(cnt);
        nres_next = nres_next + 3'd1;
      end
      if (stop || pad || end_of_string) begin
        skipping_rest_next = !end_of_string;
        if (end_of_string) begin
          byte_count_next = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_output_len <= '0;
      quad_position  <= '0;
      held_sextets   <= '0;
      third_was_pad  <= 1'b0;
      byte_count     <= '0;
      skipping_rest  <= 1'b0;
      pend_valid     <= 1'b0;
      idx            <= '0;
    end else begin
      if (cfg_write_en) begin
        max_output_len <= cfg_write_data;
      end
      if (in_fire && nres_next != 3'd0) begin
        pend_valid <= 1'b1;
        idx        <= '0;
      end else if (out_fire) begin
        if (pend_done) begin
          pend_valid <= 1'b0;
        end else begin
          idx <= idx + 2'd1;
        end
      end
      if (in_fire) begin
        quad_position <= quad_position_next;
        held_sextets  <= held_sextets_next;
        third_was_pad <= third_was_pad_next;
        byte_count    <= byte_count_next;
        skipping_rest <= skipping_rest_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && nres_next != 3'd0) begin
      res      <= res_next;
      last_idx <= 2'(nres_next - 3'd1);
    end
  end

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for base64_stream_decoder. Feeds Base64 strings
// (directed corner cases, long strings and random well-formed, broken and
// noise strings) under a range of output limits. Each transfer is decoded by
// an in-bench model and every result is checked in order against it.
// ----------------------------------------------------------------------------
module tb_top;

  typedef struct {
    b64sd_pkg::kind_t kind;
    logic [7:0]       data;
    logic [15:0]      len;
    logic             last;
  } decoded_t;

  typedef enum int {
    QUAD_FULL,
    QUAD_THIRD_PAD,
    QUAD_ONE_PAD,
    QUAD_TWO_PAD
  } quad_form_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write_en = 1'b0;
  logic [15:0] cfg_write_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  symbol = '0;
  logic        end_of_string = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  kind;
  logic [7:0]  data_byte;
  logic [15:0] total_len;
  logic        last_of_run;

  // decoder model state
  logic [1:0]  quad_pos = '0;
  logic [17:0] held = '0;
  logic        third_pad = 1'b0;
  logic [15:0] byte_cnt = '0;
  logic        skipping = 1'b0;
  logic [15:0] out_limit = '0;

  decoded_t pending_results[$];
  int       mismatches = 0;
  int       results_seen = 0;
  int       symbols_sent = 0;
  int       rx_hold = 0;
  bit       tx_pauses = 1'b0;
  bit       rx_pauses = 1'b0;

  base64_stream_decoder dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .symbol         (symbol),
    .end_of_string  (end_of_string),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .kind           (kind),
    .data_byte      (data_byte),
    .total_len      (total_len),
    .last_of_run    (last_of_run)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    #30000000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic logic [6:0] alphabet_index(input logic [7:0] c);
    if (c >= "A" && c <= "Z") return 7'(c - "A");
    if (c >= "a" && c <= "z") return 7'(c - "a" + 26);
    if (c >= "0" && c <= "9") return 7'(c - "0" + 52);
    if (c == "+") return 7'd62;
    if (c == "/") return 7'd63;
    return 7'd64;
  endfunction

  function automatic logic [7:0] alphabet_symbol(input int idx);
    if (idx < 26) return 8'("A" + idx);
    if (idx < 52) return 8'("a" + idx - 26);
    if (idx < 62) return 8'("0" + idx - 52);
    if (idx == 62) return "+";
    return "/";
  endfunction

  function automatic decoded_t make_result(input b64sd_pkg::kind_t k, input logic [7:0] d);
    decoded_t r;
    r.kind = k;
    r.data = d;
    r.len  = byte_cnt;
    r.last = 1'b0;
    return r;
  endfunction

  task automatic clear_decoder();
    quad_pos  = '0;
    held      = '0;
    third_pad = 1'b0;
    byte_cnt  = '0;
    skipping  = 1'b0;
  endtask

  task automatic halt_string(input logic eos);
    if (eos) begin
      clear_decoder();
    end else begin
      skipping  = 1'b1;
      quad_pos  = '0;
      held      = '0;
      third_pad = 1'b0;
    end
  endtask

  task automatic decode_symbol(input logic [7:0] c, input logic eos);
    decoded_t   run[$];
    logic [6:0] v;
    logic       pad;
    logic [5:0] s1, s2, s3, s4;
    logic [7:0] bytes [3];
    int         count;
    int         i;
    logic       failed;
    pad = (c == b64sd_pkg::PAD_CHAR);
    v = alphabet_index(c);
    failed = 1'b0;
    if (skipping) begin
      if (eos) clear_decoder();
    end else if (v[6] && (!pad || quad_pos < 2)) begin
      run.push_back(make_result(b64sd_pkg::KIND_ERROR, 8'h00));
      halt_string(eos);
    end else if (quad_pos < 3) begin
      if (pad) begin
        v = 7'd0;
        third_pad = 1'b1;
      end
      held = {held[11:0], v[5:0]};
      quad_pos = quad_pos + 2'd1;
      if (eos) begin
        run.push_back(make_result(b64sd_pkg::KIND_ERROR, 8'h00));
        clear_decoder();
      end
    end else begin
      s1 = held[17:12];
      s2 = held[11:6];
      s3 = held[5:0];
      s4 = pad ? 6'd0 : v[5:0];
      bytes[0] = {s1, s2[5:4]};
      bytes[1] = {s2[3:0], s3[5:2]};
      bytes[2] = {s3[1:0], s4};
      count = third_pad ? 1 : (pad ? 2 : 3);
      for (i = 0; i < count; i++) begin
        if (!failed) begin
          if (out_limit != 0 && byte_cnt >= out_limit) begin
            run.push_back(make_result(b64sd_pkg::KIND_ERROR, 8'h00));
            failed = 1'b1;
          end else begin
            if (byte_cnt != 16'hFFFF) byte_cnt = byte_cnt + 16'd1;
            run.push_back(make_result(b64sd_pkg::KIND_DATA, bytes[i]));
          end
        end
      end
      quad_pos  = '0;
      held      = '0;
      third_pad = 1'b0;
      if (failed) begin
        halt_string(eos);
      end else if (pad || eos) begin
        run.push_back(make_result(b64sd_pkg::KIND_DONE, 8'h00));
        halt_string(eos);
      end
    end
    if (run.size() > 0) run[run.size() - 1].last = 1'b1;
    foreach (run[k]) pending_results.push_back(run[k]);
  endtask

  // check each output transfer against the oldest expected result
  always @(posedge clk) begin : check_results
    decoded_t want;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: kind %0d data %02h len %0d last %0d",
                   kind, data_byte, total_len, last_of_run);
      end else begin
        want = pending_results.pop_front();
        if (kind !== want.kind || data_byte !== want.data ||
            total_len !== want.len || last_of_run !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"result %0d: expected kind %0d data %02h len %0d last %0d,",
                      " got kind %0d data %02h len %0d last %0d"},
                     results_seen, want.kind, want.data, want.len, want.last,
                     kind, data_byte, total_len, last_of_run);
        end
      end
    end
  end

  always @(posedge clk) begin : drive_out_ready
    if (rx_pauses && rx_hold == 0 && $urandom_range(0, 5) == 0)
      rx_hold = $urandom_range(1, 9);
    if (rx_hold > 0) begin
      out_ready <= 1'b0;
      rx_hold--;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic send_symbol(input logic [7:0] c, input logic eos);
    int gap;
    if (tx_pauses && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 9);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    symbol        <= c;
    end_of_string <= eos;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    decode_symbol(c, eos);
    symbols_sent++;
  endtask

  task automatic send_string(input logic [7:0] chars[$]);
    foreach (chars[i]) send_symbol(chars[i], i == chars.size() - 1);
  endtask

  task automatic send_text(input string t, input logic eos);
    int i;
    for (i = 0; i < t.len(); i++) send_symbol(t[i], eos && (i == t.len() - 1));
  endtask

  task automatic program_limit(input logic [15:0] value);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    cfg_write_en   <= 1'b1;
    cfg_write_data <= value;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    out_limit = value;
  endtask

  function automatic void append_quad(ref logic [7:0] s[$], input quad_form_t form);
    s.push_back(alphabet_symbol($urandom_range(0, 63)));
    s.push_back(alphabet_symbol($urandom_range(0, 63)));
    s.push_back((form == QUAD_THIRD_PAD || form == QUAD_TWO_PAD) ?
                b64sd_pkg::PAD_CHAR : alphabet_symbol($urandom_range(0, 63)));
    s.push_back((form == QUAD_ONE_PAD || form == QUAD_TWO_PAD) ?
                b64sd_pkg::PAD_CHAR : alphabet_symbol($urandom_range(0, 63)));
  endfunction

  task automatic test_alphabet_and_padding();
    tx_pauses = 1'b1;
    rx_pauses = 1'b1;
    program_limit(16'd0);
    send_text("AZaz09+/QQ=BAg==", 1'b1);
    send_text("QUI=ZZ", 1'b0);
    send_text("Z", 1'b1);
  endtask

  task automatic test_bad_symbols();
    send_text("=", 1'b1);
    send_text("Q=", 1'b1);
    send_symbol("Q", 1'b0);
    send_symbol(8'hFF, 1'b1);
    send_symbol(8'h00, 1'b1);
  endtask

  task automatic test_short_tails();
    send_text("Q", 1'b1);
    send_text("QU", 1'b1);
    send_text("QU=", 1'b1);
  endtask

  task automatic test_output_limit();
    program_limit(16'd1);
    send_text("QUJD", 1'b1);
    program_limit(16'd4);
    send_text("QUJDRA==", 1'b1);
  endtask

  // send long strings back to back: one ending in a two-pad quad, then an unpadded one under the widest limit
  task automatic test_long_strings();
    logic [7:0] s[$];
    tx_pauses = 1'b0;
    rx_pauses = 1'b0;
    program_limit(16'd0);
    repeat (10) append_quad(s, QUAD_FULL);
    append_quad(s, QUAD_TWO_PAD);
    send_string(s);
    s.delete();
    program_limit(16'hFFFF);
    repeat (10) append_quad(s, QUAD_FULL);
    send_string(s);
  endtask

  task automatic send_random_string();
    logic [7:0] s[$];
    int         pick;
    int         quads;
    int         pos;
    int         i;
    pick = $urandom_range(0, 9);
    if (pick < 8) begin
      quads = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 10) : $urandom_range(1, 4);
      for (i = 0; i < quads - 1; i++)
        append_quad(s, ($urandom_range(0, 4) == 0) ? QUAD_THIRD_PAD : QUAD_FULL);
      append_quad(s, quad_form_t'($urandom_range(0, 3)));
      if ($urandom_range(0, 4) == 0)
        repeat ($urandom_range(1, 5)) s.push_back(alphabet_symbol($urandom_range(0, 63)));
      if (pick >= 6) begin
        pos = $urandom_range(0, s.size() - 1);
        case ($urandom_range(0, 2))
          0: begin
            s[pos] = 8'($urandom_range(0, 255));
          end
          1: begin
            s[pos] = b64sd_pkg::PAD_CHAR;
          end
          default: begin
            repeat ($urandom_range(1, 3)) if (s.size() > 1) void'(s.pop_back());
          end
        endcase
      end
    end else begin
      repeat ($urandom_range(1, 8)) s.push_back(8'($urandom_range(0, 255)));
    end
    send_string(s);
  endtask

  task automatic test_random_streams();
    logic [15:0] limits [6];
    int          phase;
    int          start;
    limits = '{16'd0, 16'd3, 16'd1, 16'd7, 16'hFFFF, 16'd0};
    for (phase = 0; phase < 6; phase++) begin
      program_limit(limits[phase]);
      tx_pauses = (phase < 5) && (phase != 2);
      rx_pauses = (phase < 5) && (phase != 3);
      start = symbols_sent;
      while (symbols_sent - start < 60) send_random_string();
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_alphabet_and_padding();
    test_bad_symbols();
    test_short_tails();
    test_output_limit();
    test_long_strings();
    test_random_streams();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("Covered %0d symbols (corner cases, long strings, random streams)",
             symbols_sent);
    $display("under output limits 0 to 65535: %0d results checked, %0d mismatches",
             results_seen, mismatches);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
